@@ hw/rtl/binary_trie_max_xor_top_assert.svh @@
// ----------------------------------------------------------------------------
// Binary trie max-XOR assertion macros
// Shared concurrent assertion macros. Clocked on clk, held off during rst.
// ----------------------------------------------------------------------------
`ifndef BINARY_TRIE_MAX_XOR_TOP_ASSERT_SVH
`define BINARY_TRIE_MAX_XOR_TOP_ASSERT_SVH
`ifndef ASSERT_OFF
// prop must hold at every edge outside reset
`define BTMX_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// expr must never be true outside reset
`define BTMX_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define BTMX_ASSERT(label, prop, msg)
`define BTMX_NEVER(label, expr, msg)
`endif
`endif

@@ hw/rtl/btmx_pkg.sv @@
// ----------------------------------------------------------------------------
// Binary trie max-XOR package
// Shared types, codes and sizing helpers.
// ----------------------------------------------------------------------------
package btmx_pkg;

  localparam int NODES_DEF      = 4096;
  localparam int TRIES_DEF      = 4;
  localparam int KEY_BITS_DEF   = 31;
  localparam int COUNT_BITS_DEF = 20;

  localparam int KEY_W       = 31;
  localparam int TDATA_W     = 32;
  localparam int TUSER_IN_W  = 4;
  localparam int TUSER_OUT_W = 2;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_ERASE  = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_FULL   = 2'd1,
    STATUS_ABSENT = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_t;

  // walk kind carried down the cell row
  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_CHECK  = 2'd1,
    MODE_ERASE  = 2'd2,
    MODE_QUERY  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'd0,
    ST_LAUNCH = 2'd1,
    ST_WALK   = 2'd2,
    ST_DONE   = 2'd3
  } state_t;

  typedef struct packed {
    logic  valid;
    logic  ok;
    mode_t mode;
  } ctl_t;

  // node slots held by the cell at a given trie depth (ids start at 1 below the roots)
  function automatic int cell_depth(input int level, input int nodes, input int tries);
    longint n;
    n = longint'(tries) << level;
    if (level == 0) return (tries < 2) ? 2 : tries;
    if (n > longint'(nodes)) return nodes + 1;
    return int'(n) + 1;
  endfunction

endpackage

@@ hw/rtl/btmx_cell.sv @@
// ----------------------------------------------------------------------------
// Binary trie max-XOR level cell
// Holds all trie nodes of one depth; steps one request through one key bit.
// ----------------------------------------------------------------------------
`include "binary_trie_max_xor_top_assert.svh"

module btmx_cell #(
  parameter int LEVEL      = 0,
  parameter int DEPTH      = 2,
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = btmx_pkg::COUNT_BITS_DEF,
  parameter int ID_W       = 13
) (
  input  logic                           clk,
  input  logic                           rst,
  input  btmx_pkg::ctl_t                 in_ctl,
  input  logic [KEY_BITS-1:0]            in_key,
  input  logic [KEY_BITS-1:0]            in_res,
  input  logic [$clog2(KEY_BITS+1)-1:0]  in_created,
  input  logic [ID_W-1:0]                in_addr,
  input  logic                           in_zero,
  output btmx_pkg::ctl_t                 out_ctl,
  output logic [KEY_BITS-1:0]            out_key,
  output logic [KEY_BITS-1:0]            out_res,
  output logic [$clog2(KEY_BITS+1)-1:0]  out_created,
  output logic [ID_W-1:0]                out_addr,
  output logic                           out_zero
);
  import btmx_pkg::*;

  localparam int AW  = $clog2(DEPTH);
  localparam int BIT = KEY_BITS - 1 - LEVEL;
  localparam int CW  = $clog2(KEY_BITS + 1);
  localparam int EW  = 2 * ID_W + 2 * COUNT_BITS;

  // entry: {count1, count0, link1, link0}, counts are of the children
  logic [EW-1:0] mem [DEPTH];

  ctl_t            ctl_r;
  logic [KEY_BITS-1:0] key_r, res_r;
  logic [CW-1:0]   created_r;
  logic [AW-1:0]   addr_r;
  logic            zero_r;
  logic [EW-1:0]   rd;
  logic [ID_W-1:0] alloc, alloc_next;

  logic [EW-1:0]         entry, wdata;
  logic [ID_W-1:0]       lk0, lk1, lk_b, lk_o, new_lk_b, nxt;
  logic [COUNT_BITS-1:0] c0, c1, c_b, c_o, new_c_b;
  logic                  b, made, wr;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_r <= '0;
      alloc <= ID_W'(1);
    end else begin
      ctl_r <= in_ctl;
      alloc <= alloc_next;
    end
  end

  always_ff @(posedge clk) begin
    key_r     <= in_key;
    res_r     <= in_res;
    created_r <= in_created;
    addr_r    <= in_addr[AW-1:0];
    zero_r    <= in_zero;
  end

  always_ff @(posedge clk) begin
    rd <= mem[in_addr[AW-1:0]];
    if (wr) begin
      mem[addr_r] <= wdata;
    end
  end

  always_comb begin
    // unwritten or null nodes read as empty
    entry = zero_r ? '0 : rd;
    lk0   = entry[ID_W-1:0];
    lk1   = entry[2*ID_W-1:ID_W];
    c0    = entry[2*ID_W +: COUNT_BITS];
    c1    = entry[2*ID_W+COUNT_BITS +: COUNT_BITS];
    b     = key_r[BIT];
    lk_b  = b ? lk1 : lk0;
    lk_o  = b ? lk0 : lk1;
    c_b   = b ? c1 : c0;
    c_o   = b ? c0 : c1;

    out_ctl     = ctl_r;
    out_key     = key_r;
    out_res     = res_r;
    out_created = created_r;
    new_lk_b    = lk_b;
    new_c_b     = c_b;
    nxt         = lk_b;
    made        = 1'b0;
    wr          = 1'b0;
    alloc_next  = alloc;

    if (ctl_r.valid) begin
      unique case (ctl_r.mode)
        MODE_INSERT: begin
          if (lk_b == '0) begin
            new_lk_b    = alloc;
            alloc_next  = alloc + ID_W'(1);
            made        = 1'b1;
            out_created = created_r + CW'(1);
          end
          new_c_b = c_b + COUNT_BITS'(1);
          nxt     = new_lk_b;
          wr      = 1'b1;
        end
        MODE_CHECK: begin
          if (c_b == '0) out_ctl.ok = 1'b0;
        end
        MODE_ERASE: begin
          new_c_b = c_b - COUNT_BITS'(1);
          wr      = 1'b1;
        end
        MODE_QUERY: begin
          if (c_o != '0) begin
            out_res[BIT] = 1'b1;
            nxt          = lk_o;
          end
        end
        default: ;
      endcase
    end

    wdata    = b ? {new_c_b, c0, new_lk_b, lk0} : {c1, new_c_b, lk1, new_lk_b};
    out_addr = nxt;
    out_zero = made | (nxt == '0);
  end

  `BTMX_ASSERT(a_one_request, ctl_r.valid |=> !ctl_r.valid, "cell saw back-to-back requests")
  `BTMX_NEVER(a_erase_underflow, ctl_r.valid && ctl_r.mode == MODE_ERASE && c_b == '0, "erase underflow")
  `BTMX_NEVER(a_insert_overflow, ctl_r.valid && ctl_r.mode == MODE_INSERT && c_b == '1, "count overflow")

endmodule

@@ hw/rtl/binary_trie_max_xor_top.sv @@
// ----------------------------------------------------------------------------
// Binary trie max-XOR top level
// Several count-carrying binary tries; insert, erase and max-XOR query.
// ----------------------------------------------------------------------------
// Channel  Dir  Fields
// s_*      in   tuser[1:0] op, tuser[3:2] trie_index, tdata[30:0] key
// m_*      out  tdata[30:0] max_xor, tuser[1:0] status
//
// One request at a time. Insert and query make one walk down the row; erase makes
// two: one row walk to check the key, one to lower the counts (only the check walk
// if the check fails). Row of KEY_BITS cells, one key bit each. Op 3, full inserts
// and empty queries skip the row walk.
// No clearing pass after reset: fresh nodes are flagged along the walk.
// A finished result waits in the output register; a new request is taken then.
// ----------------------------------------------------------------------------
`include "binary_trie_max_xor_top_assert.svh"

module binary_trie_max_xor_top #(
  parameter int NODES      = btmx_pkg::NODES_DEF,
  parameter int TRIES      = btmx_pkg::TRIES_DEF,
  parameter int KEY_BITS   = btmx_pkg::KEY_BITS_DEF,
  parameter int COUNT_BITS = btmx_pkg::COUNT_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [btmx_pkg::TDATA_W-1:0]     s_tdata,   // key
  input  logic [btmx_pkg::TUSER_IN_W-1:0]  s_tuser,   // op, trie_index
  output logic                             m_tvalid,
  input  logic                             m_tready,
  output logic [btmx_pkg::TDATA_W-1:0]     m_tdata,   // max_xor
  output logic [btmx_pkg::TUSER_OUT_W-1:0] m_tuser    // status
);
  import btmx_pkg::*;

  localparam int ID_W = $clog2(NODES + 1);
  localparam int TW   = (TRIES > 1) ? $clog2(TRIES) : 1;
  localparam int CW   = $clog2(KEY_BITS + 1);

  state_t state, state_next;
  op_t    op_q;
  mode_t  mode_q, mode_next;
  logic [TW-1:0]       root_q, root_in;
  logic [KEY_BITS-1:0] key_q, key_in, res_q, res_next;
  status_t             status_q, status_next;

  // node pool fill and per-trie root state
  logic [ID_W-1:0]       next_free, next_free_next;
  logic [COUNT_BITS-1:0] root_cnt [TRIES];
  logic [TRIES-1:0]      root_used;
  logic                  rc_inc, rc_dec;

  logic [KEY_W-1:0] out_xor;
  logic             load_out, launch_go, pool_full;
  logic [COUNT_BITS-1:0] rc;
  logic [32:0]      key_ext, res_ext;

  // cell row links
  ctl_t                ch_ctl     [KEY_BITS+1];
  logic [KEY_BITS-1:0] ch_key     [KEY_BITS+1];
  logic [KEY_BITS-1:0] ch_res     [KEY_BITS+1];
  logic [CW-1:0]       ch_created [KEY_BITS+1];
  logic [ID_W-1:0]     ch_addr    [KEY_BITS+1];
  logic                ch_zero    [KEY_BITS+1];

  // trie selector folded into range, key trimmed to KEY_BITS
  always_comb begin
    int r;
    r = int'(s_tuser[3:2]);
    for (int k = 0; k < 4; k++) begin
      if (r >= TRIES) r = r - TRIES;
    end
    root_in = TW'(r);
    key_ext = 33'(s_tdata[KEY_W-1:0]);
    key_in  = key_ext[KEY_BITS-1:0];
  end

  assign s_tready = (state == ST_IDLE);
  assign rc       = root_cnt[root_q];
  assign pool_full = ((ID_W+1)'(next_free) + (ID_W+1)'(KEY_BITS)) > (ID_W+1)'(NODES);

  // head of the row
  assign ch_ctl[0]     = '{valid: launch_go, ok: 1'b1, mode: mode_q};
  assign ch_key[0]     = key_q;
  assign ch_res[0]     = '0;
  assign ch_created[0] = '0;
  assign ch_addr[0]    = ID_W'(root_q);
  assign ch_zero[0]    = !root_used[root_q];

  for (genvar g = 0; g < KEY_BITS; g++) begin : g_cell
    btmx_cell #(
      .LEVEL      (g),
      .DEPTH      (cell_depth(g, NODES, TRIES)),
      .KEY_BITS   (KEY_BITS),
      .COUNT_BITS (COUNT_BITS),
      .ID_W       (ID_W)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .in_ctl      (ch_ctl[g]),
      .in_key      (ch_key[g]),
      .in_res      (ch_res[g]),
      .in_created  (ch_created[g]),
      .in_addr     (ch_addr[g]),
      .in_zero     (ch_zero[g]),
      .out_ctl     (ch_ctl[g+1]),
      .out_key     (ch_key[g+1]),
      .out_res     (ch_res[g+1]),
      .out_created (ch_created[g+1]),
      .out_addr    (ch_addr[g+1]),
      .out_zero    (ch_zero[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      m_tvalid  <= 1'b0;
      next_free <= ID_W'(TRIES + 1);
      root_used <= '0;
      for (int t = 0; t < TRIES; t++) root_cnt[t] <= '0;
    end else begin
      state     <= state_next;
      next_free <= next_free_next;
      if (load_out) m_tvalid <= 1'b1;
      else if (m_tready) m_tvalid <= 1'b0;
      if (rc_inc) begin
        root_cnt[root_q]  <= rc + COUNT_BITS'(1);
        root_used[root_q] <= 1'b1;
      end else if (rc_dec) begin
        root_cnt[root_q] <= rc - COUNT_BITS'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    mode_q   <= mode_next;
    res_q    <= res_next;
    status_q <= status_next;
    if (s_tvalid && s_tready) begin
      op_q   <= op_t'(s_tuser[1:0]);
      root_q <= root_in;
      key_q  <= key_in;
    end
    if (load_out) out_xor <= res_ext[KEY_W-1:0];
    if (load_out) m_tuser <= status_q;
  end

  assign res_ext = 33'(res_q);
  assign m_tdata = TDATA_W'(out_xor);

  always_comb begin
    state_next     = state;
    mode_next      = mode_q;
    res_next       = res_q;
    status_next    = status_q;
    next_free_next = next_free;
    launch_go      = 1'b0;
    rc_inc         = 1'b0;
    rc_dec         = 1'b0;
    load_out       = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          res_next    = '0;
          status_next = STATUS_OK;
          unique case (op_t'(s_tuser[1:0]))
            OP_INSERT: mode_next = MODE_INSERT;
            OP_ERASE:  mode_next = MODE_CHECK;
            OP_QUERY:  mode_next = MODE_QUERY;
            OP_NONE:   mode_next = MODE_QUERY;
            default:   mode_next = MODE_QUERY;
          endcase
          state_next = ST_LAUNCH;
        end
      end
      ST_LAUNCH: begin
        priority if (op_q == OP_NONE) begin
          state_next = ST_DONE;
        end else if (op_q == OP_INSERT && (pool_full || rc == '1)) begin
          status_next = STATUS_FULL;
          state_next  = ST_DONE;
        end else if (op_q == OP_QUERY && rc == '0) begin
          status_next = STATUS_EMPTY;
          state_next  = ST_DONE;
        end else begin
          launch_go  = 1'b1;
          rc_inc     = (mode_q == MODE_INSERT);
          rc_dec     = (mode_q == MODE_ERASE);
          state_next = ST_WALK;
        end
      end
      ST_WALK: begin
        if (ch_ctl[KEY_BITS].valid) begin
          state_next = ST_DONE;
          unique case (mode_q)
            MODE_CHECK: begin
              if (ch_ctl[KEY_BITS].ok) begin
                mode_next  = MODE_ERASE;
                state_next = ST_LAUNCH;
              end else begin
                status_next = STATUS_ABSENT;
              end
            end
            MODE_INSERT: next_free_next = next_free + ID_W'(ch_created[KEY_BITS]);
            MODE_ERASE:  ;
            MODE_QUERY:  res_next = ch_res[KEY_BITS];
            default:     ;
          endcase
        end
      end
      ST_DONE: begin
        if (!m_tvalid || m_tready) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  `BTMX_ASSERT(a_tail_in_walk, ch_ctl[KEY_BITS].valid |-> state == ST_WALK, "row done outside walk")
  `BTMX_ASSERT(a_pool_bound, next_free <= ID_W'(NODES), "node pool overrun")
  `BTMX_ASSERT(a_xor_only_ok, m_tvalid && m_tdata != '0 |-> m_tuser == STATUS_OK, "xor with bad status")

endmodule
